/* rtl/ial_pkg.sv */
// ============================================================================
// ial_pkg
// Shared types and constants for the indexed array list core: operation and
// status codes, the per-cell command and the controller-to-cell control beat.
// ============================================================================
package ial_pkg;

    // Default geometry
    localparam int CAPACITY_DEF  = 16;
    localparam int DATA_BITS_DEF = 32;

    // Width that holds any position or fill up to the largest capacity (256)
    localparam int POS_W = 9;

    // Fixed field widths of the channels
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 5;
    localparam int COUNT_W  = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POPPED_W = 32;
    localparam int FILL_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_REMOVE = 3'd2,
        OP_POP    = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_BAD   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DOWN = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [POS_W-1:0]   pos;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_SHIFT = 1'b1
    } fsm_t;

endpackage

/* rtl/ial_cell.sv */
// ============================================================================
// ial_cell
// One list slot. On insert it takes the new word at the insert position and
// its lower neighbor's word above it; on a shift-down step it takes its upper
// neighbor's word at and above the removal position.
// ============================================================================
module ial_cell
    import ial_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF,
    parameter int IDX       = 0
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [DATA_BITS-1:0] ins_data,
    input  logic [DATA_BITS-1:0] left_data,
    input  logic [DATA_BITS-1:0] right_data,
    output logic [DATA_BITS-1:0] data
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [DATA_BITS-1:0] data_reg;
    logic [DATA_BITS-1:0] data_next;

    // Select the next word for this slot
    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            CELL_INS:
            begin
                if (MY_POS == ctrl.pos)
                begin
                    data_next = ins_data;
                end
                else if (MY_POS > ctrl.pos)
                begin
                    data_next = left_data;
                end
            end
            CELL_DOWN:
            begin
                if (MY_POS >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the slot word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/ial_ctrl.sv */
// ============================================================================
// ial_ctrl
// List controller: decodes each input beat, checks it against the fill count,
// drives the cell row, steps multi-entry removals and registers the result.
// ============================================================================
module ial_ctrl
    import ial_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_W-1:0]              op,
    input  logic [INDEX_W-1:0]           index,
    input  logic [COUNT_W-1:0]           count,
    input  logic [VALUE_W-1:0]           value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [STATUS_W-1:0]          status,
    output logic [POPPED_W-1:0]          popped,
    output logic [FILL_W-1:0]            fill,
    output cell_ctrl_t                   cell_ctrl,
    output logic [DATA_BITS-1:0]         ins_data,
    output logic [$clog2(CAPACITY)-1:0]  tail_addr,
    input  logic [DATA_BITS-1:0]         tail_data
);

    localparam int UW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    fsm_t                 state_reg, state_next;
    logic [UW-1:0]        used_reg, used_next;
    logic [UW-1:0]        left_reg, left_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [POPPED_W-1:0]  popped_reg, popped_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;

    logic                 accept;
    logic [POS_W-1:0]     used_w;
    logic [POS_W-1:0]     idx_w;
    logic [POS_W-1:0]     cnt_w;
    logic [UW-1:0]        used_dec;
    logic [63:0]          value_ext;
    logic [63:0]          tail_ext;
    status_t              stat;
    logic [POPPED_W-1:0]  pop_val;

    assign used_w    = POS_W'(used_reg);
    assign idx_w     = POS_W'(index);
    assign cnt_w     = POS_W'(count);
    assign used_dec  = used_reg - UW'(1);
    assign tail_addr = used_dec[IW-1:0];
    assign value_ext = 64'(value);
    assign tail_ext  = 64'(tail_data);
    assign ins_data  = value_ext[DATA_BITS-1:0];

    // Stall input during removal steps or while a result waits
    assign in_stall = (state_reg != FSM_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // Decode the beat, drive the cells, advance the removal steps
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        stat           = STAT_BAD;
        pop_val        = '0;
        cell_ctrl.cmd  = CELL_HOLD;
        cell_ctrl.pos  = idx_w;

        unique case (state_reg)
            FSM_SHIFT:
            begin
                cell_ctrl.cmd = CELL_DOWN;
                cell_ctrl.pos = pos_reg;
                left_next     = left_reg - UW'(1);
                if (left_reg == UW'(1))
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                if (accept)
                begin
                    unique case (op_t'(op))
                        OP_INSERT:
                        begin
                            priority if (idx_w > used_w)
                            begin
                                stat = STAT_BAD;
                            end
                            else if (used_w >= CAP_POS)
                            begin
                                stat = STAT_FULL;
                            end
                            else
                            begin
                                stat          = STAT_OK;
                                cell_ctrl.cmd = CELL_INS;
                                cell_ctrl.pos = idx_w;
                                used_next     = used_reg + UW'(1);
                            end
                        end
                        OP_APPEND:
                        begin
                            if (used_w >= CAP_POS)
                            begin
                                stat = STAT_FULL;
                            end
                            else
                            begin
                                stat          = STAT_OK;
                                cell_ctrl.cmd = CELL_INS;
                                cell_ctrl.pos = used_w;
                                used_next     = used_reg + UW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            priority if (idx_w >= used_w)
                            begin
                                stat = STAT_BAD;
                            end
                            else if (cnt_w > (used_w - idx_w))
                            begin
                                stat = STAT_BAD;
                            end
                            else
                            begin
                                stat      = STAT_OK;
                                used_next = used_reg - UW'(count);
                                // First shift step goes with the accepting beat
                                if (count != '0)
                                begin
                                    cell_ctrl.cmd = CELL_DOWN;
                                    cell_ctrl.pos = idx_w;
                                end
                                if (cnt_w > POS_W'(1))
                                begin
                                    state_next = FSM_SHIFT;
                                    left_next  = UW'(count) - UW'(1);
                                    pos_next   = idx_w;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (used_reg == '0)
                            begin
                                stat = STAT_EMPTY;
                            end
                            else
                            begin
                                stat      = STAT_OK;
                                used_next = used_dec;
                                pop_val   = tail_ext[POPPED_W-1:0];
                            end
                        end
                        OP_CLEAR:
                        begin
                            stat      = STAT_OK;
                            used_next = '0;
                        end
                        default:
                        begin
                            stat = STAT_BAD;
                        end
                    endcase
                end
            end
        endcase
    end

    // Load the result register on accept, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        fill_next      = fill_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = stat;
            popped_next    = pop_val;
            fill_next      = FILL_W'(used_next);
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            used_reg      <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        fill_reg   <= fill_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign popped    = popped_reg;
    assign fill      = fill_reg;

endmodule

/* rtl/indexed_array_list_core.sv */
// ============================================================================
// indexed_array_list_core
// Fixed-capacity ordered list of words held in a row of cells. Supports
// insert at index, append, removal of a run, pop of the last entry and clear.
//
//   Channel | Beat fields              | Handshake
//   --------+--------------------------+----------------------
//   in      | op, index, count, value  | in_valid / in_stall
//   out     | status, popped, fill     | out_valid / out_stall
//
// Insert, append, pop, clear and errors finish in the accepting beat; a removal
// run of count entries shifts the cell row once per cycle from that beat on,
// and the next input beat is stalled until the run is done.
// The result is registered and shows the cycle after the input beat.
// Reset clears only the fill count and control; slot words are not cleared.
// While a result is stalled the input is stalled too.
// ============================================================================
module indexed_array_list_core
    import ial_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [INDEX_W-1:0]  index,
    input  logic [COUNT_W-1:0]  count,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [POPPED_W-1:0] popped,
    output logic [FILL_W-1:0]   fill
);

    localparam int IW = $clog2(CAPACITY);

    cell_ctrl_t            cell_ctrl;
    logic [DATA_BITS-1:0]  ins_data;
    logic [IW-1:0]         tail_addr;
    logic [DATA_BITS-1:0]  tail_data;
    logic [DATA_BITS-1:0]  slot_data [CAPACITY];

    ial_ctrl #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .index     (index),
        .count     (count),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .popped    (popped),
        .fill      (fill),
        .cell_ctrl (cell_ctrl),
        .ins_data  (ins_data),
        .tail_addr (tail_addr),
        .tail_data (tail_data)
    );

    // Row of slots, each wired to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_BITS-1:0] left_w;
        logic [DATA_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = ins_data;
        end
        else
        begin : g_mid_l
            assign left_w = slot_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = slot_data[i];
        end
        else
        begin : g_mid_r
            assign right_w = slot_data[i+1];
        end

        ial_cell #(
            .DATA_BITS (DATA_BITS),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .ins_data   (ins_data),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (slot_data[i])
        );
    end

    // Read the last held word for pop
    assign tail_data = slot_data[tail_addr];

endmodule

/* rtl/ial_checker.sv */
// ============================================================================
// ial_checker
// Port-level checks on the indexed array list core: result timing, clear and
// error results, and holding of a stalled result beat.
// ============================================================================
module ial_checker
    import ial_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [OP_W-1:0]     op,
    input logic [STATUS_W-1:0] status,
    input logic [POPPED_W-1:0] popped,
    input logic [FILL_W-1:0]   fill,
    input logic                out_valid,
    input logic                out_stall
);

    // Every accepted beat yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("no result after accepted beat");

    // Clear always succeeds and empties the list
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_CLEAR) |=>
        (status == STAT_OK && fill == '0))
        else $error("clear did not empty the list");

    // Only a successful beat can carry a popped word
    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_OK) |-> popped == '0)
        else $error("popped word on failed beat");

    // Empty status reports an empty list
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_EMPTY) |-> fill == '0)
        else $error("empty status with nonzero fill");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(status) && $stable(popped) && $stable(fill)))
        else $error("stalled result changed");

endmodule

bind indexed_array_list_core ial_checker u_ial_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .status    (status),
    .popped    (popped),
    .fill      (fill),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
